@@ src/mpe_voice_channel_tracker_assert.svh @@
// ----------------------------------------------------------------------------
// MPE voice channel tracker assertion macros
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef MPE_VOICE_CHANNEL_TRACKER_ASSERT_SVH
`define MPE_VOICE_CHANNEL_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF

// The antecedent holding at an edge implies the consequent at that same edge.
`define MVT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// The antecedent holding at an edge implies the consequent at the next edge.
`define MVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`else

`define MVT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MVT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ src/mvt_pkg.sv @@
// ----------------------------------------------------------------------------
// MPE voice channel tracker package
// Shared widths, operation and result codes, entry types and level formatting.
// ----------------------------------------------------------------------------
package mvt_pkg;

   localparam int CHANNELS_DEF = 16;

   localparam int CHAN_W     = 5;
   localparam int KEY_W      = 7;
   localparam int CTL_W      = 7;
   localparam int AMT_W      = 14;
   localparam int VAL7_W     = 7;
   localparam int LEVEL_W    = 15;
   localparam int BEND_W     = 23;
   localparam int FUNC_W     = 3;
   localparam int KIND_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;
   localparam int MAG_W      = 13;
   localparam int PROD_W     = 20;

   localparam logic [AMT_W-1:0] BEND_CENTRE = 14'd8192;
   localparam logic [CTL_W-1:0] TIMBRE_CC   = 7'd74;

   // Input operation codes.
   localparam logic [FUNC_W-1:0] FUNC_NOTE_ON  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_BEND     = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CC       = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PRESSURE = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_DUMP     = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH    = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_RESET    = 3'd7;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_NOTE     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_OFF      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BEND     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_GBEND    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TIMBRE   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PRESSURE = 3'd5;
   localparam logic [KIND_W-1:0] KIND_STATE    = 3'd6;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_FIRST = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_LAST  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMALIZE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BEND_RANGE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SEMI_MODE  = 3'd5;

   // Configuration reset values.
   localparam logic [CHAN_W-1:0] ZONE_FIRST_RST = 5'd2;
   localparam logic [CHAN_W-1:0] ZONE_LAST_RST  = 5'd16;
   localparam logic [CHAN_W-1:0] MASTER_RST     = 5'd1;
   localparam logic [VAL7_W-1:0] BEND_RANGE_RST = 7'd48;

   typedef struct packed {
      logic                active;
      logic [KEY_W-1:0]    key;
      logic [VAL7_W-1:0]   velocity;
      logic [AMT_W-1:0]    bend_raw;
      logic [VAL7_W-1:0]   timbre;
      logic [VAL7_W-1:0]   pressure;
   } voice_entry_type;

   typedef struct packed {
      logic                we_active;
      logic                active;
      logic                we_note;
      logic [KEY_W-1:0]    key;
      logic [VAL7_W-1:0]   velocity;
      logic                we_bend;
      logic [AMT_W-1:0]    bend_raw;
      logic                we_timbre;
      logic [VAL7_W-1:0]   timbre;
      logic                we_pressure;
      logic [VAL7_W-1:0]   pressure;
   } voice_wr_type;

   function automatic logic [VAL7_W-1:0] sat7(input logic [AMT_W-1:0] amt);
      if (amt > 14'd127) begin
         return 7'd127;
      end
      return amt[VAL7_W-1:0];
   endfunction

   // (v*32768+63)/127 written as 258*v plus a quotient of 0..2, since
   // 32768 = 258*127 + 2.
   function automatic logic [LEVEL_W-1:0] level_fmt(input logic [VAL7_W-1:0] v,
                                                    input logic norm);
      logic [8:0]  t;
      logic [1:0]  qa;
      logic [15:0] s;
      t = {1'b0, v, 1'b0} + 9'd63;
      if (t >= 9'd254) begin
         qa = 2'd2;
      end else if (t >= 9'd127) begin
         qa = 2'd1;
      end else begin
         qa = 2'd0;
      end
      s = {1'b0, v, 8'b0} + {8'b0, v, 1'b0} + {14'b0, qa};
      if (!norm) begin
         return {8'b0, v};
      end else if (s > 16'd32767) begin
         return 15'h7fff;
      end
      return s[LEVEL_W-1:0];
   endfunction

endpackage

@@ src/mvt_if.sv @@
// ----------------------------------------------------------------------------
// MPE voice channel tracker channel interfaces
// Valid/ready request and response channels carrying one word each.
// ----------------------------------------------------------------------------
interface mvt_req_if;
   logic                            valid;
   logic                            ready;
   logic [mvt_pkg::FUNC_W-1:0]      func;
   logic [mvt_pkg::CHAN_W-1:0]      chan;
   logic [mvt_pkg::KEY_W-1:0]       key;
   logic [mvt_pkg::CTL_W-1:0]       controller;
   logic [mvt_pkg::AMT_W-1:0]       amount;

   modport source (output valid, func, chan, key, controller, amount, input ready);
   modport sink   (input valid, func, chan, key, controller, amount, output ready);
endinterface

interface mvt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mvt_pkg::KIND_W-1:0]      kind;
   logic [mvt_pkg::CHAN_W-1:0]      out_chan;
   logic [mvt_pkg::KEY_W-1:0]       out_key;
   logic [mvt_pkg::LEVEL_W-1:0]     level;
   logic signed [mvt_pkg::BEND_W-1:0] bend_out;
   logic [mvt_pkg::LEVEL_W-1:0]     timbre_out;
   logic [mvt_pkg::LEVEL_W-1:0]     pressure_out;
   logic                            last;

   modport source (output valid, kind, out_chan, out_key, level, bend_out, timbre_out,
                   pressure_out, last, input ready);
   modport sink   (input valid, kind, out_chan, out_key, level, bend_out, timbre_out,
                   pressure_out, last, output ready);
endinterface

@@ src/mpe_voice_channel_tracker.sv @@
// ----------------------------------------------------------------------------
// MPE voice channel tracker
// Keeps one voice entry per MIDI channel of an MPE zone plus the zone master
// bend, and turns incoming MIDI events into formatted voice results.
//
// Usage: a request word carries func, chan, key, controller and amount and is
// taken on req_ch when valid and ready are both high. Each result word leaves
// on rsp_ch under the same handshake. Configuration is written on the csr_
// port, one register per cycle; the user must write it only while the block
// is idle, which the block does not enforce. After acceptance the execute
// state reads the voice entry and registers the bend product; the calc state
// divides and loads the output register, then ready returns. Dump and flush
// walk every channel: a channel with nothing to report takes only the execute
// state, a reported voice also the calc state for the shared bend unit.
// Reset clears the voice entries and restores the register defaults at once;
// no clearing pass is needed. When the receiver stalls, the finished word
// waits in the output register and the walk holds until it is taken.
// ----------------------------------------------------------------------------
`include "mpe_voice_channel_tracker_assert.svh"

module mpe_voice_channel_tracker #(
   parameter int CHANNELS = mvt_pkg::CHANNELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   mvt_req_if.sink                            req_ch,
   mvt_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [mvt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mvt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(CHANNELS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

   // The sequencer: wait for a word, act on one voice entry, format it.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_CALC = 3'b100
   } state_type;

   // Result fields held while the bend unit finishes.
   typedef struct packed {
      logic [mvt_pkg::KIND_W-1:0]  kind;
      logic [mvt_pkg::CHAN_W-1:0]  chan;
      logic [mvt_pkg::KEY_W-1:0]   key;
      logic [mvt_pkg::LEVEL_W-1:0] level;
      logic [mvt_pkg::LEVEL_W-1:0] timbre;
      logic [mvt_pkg::LEVEL_W-1:0] pressure;
      logic                        use_bend;
      logic                        last;
   } pend_type;

   // Configuration registers.
   logic [mvt_pkg::CHAN_W-1:0] zone_first_ff;
   logic [mvt_pkg::CHAN_W-1:0] zone_last_ff;
   logic [mvt_pkg::CHAN_W-1:0] master_ff;
   logic                       normalize_ff;
   logic [mvt_pkg::VAL7_W-1:0] bend_range_ff;
   logic                       semi_mode_ff;

   // Sequencer and captured request word.
   state_type                   state_ff, state_in;
   logic [IDX_W-1:0]            cnt_ff, cnt_in;
   logic [mvt_pkg::FUNC_W-1:0]  func_ff;
   logic [mvt_pkg::CHAN_W-1:0]  chan_ff;
   logic [mvt_pkg::KEY_W-1:0]   key_ff;
   logic [mvt_pkg::CTL_W-1:0]   ctl_ff;
   logic [mvt_pkg::AMT_W-1:0]   amt_ff;
   logic [mvt_pkg::AMT_W-1:0]   master_raw_ff;

   pend_type                    pend_ff, pend_in;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   pend_type                    rsp_word_ff;
   logic signed [mvt_pkg::BEND_W-1:0] rsp_bend_ff;

   // Datapath signals.
   logic                        req_take;
   logic                        walking;
   logic                        has_res;
   logic                        master_we;
   logic                        store_clear;
   logic                        out_load;
   logic                        inz;
   logic                        walk_inz;
   logic [mvt_pkg::CHAN_W-1:0]  chan_m1;
   logic [mvt_pkg::CHAN_W-1:0]  walk_chan;
   logic [mvt_pkg::AMT_W-1:0]   v_bend;
   logic [mvt_pkg::VAL7_W-1:0]  v7;
   logic [mvt_pkg::AMT_W-1:0]   bend_raw_sel;
   logic [IDX_W-1:0]            addr;
   logic [CHANNELS-1:0]         active_vec;
   logic [CHANNELS-1:0]         zone_vec;
   logic [CHANNELS-1:0]         rest_vec;
   logic signed [mvt_pkg::BEND_W-1:0] bend_val;
   mvt_pkg::voice_wr_type       wr;
   mvt_pkg::voice_entry_type    entry;

   // A channel is in the zone when it is a real note channel of this block and
   // lies between the first and last zone channels; first after last is empty.
   function automatic logic in_zone(input logic [mvt_pkg::CHAN_W-1:0] ch,
                                    input logic [mvt_pkg::CHAN_W-1:0] first,
                                    input logic [mvt_pkg::CHAN_W-1:0] lastc);
      return (ch >= 5'd1) && (ch <= 5'(CHANNELS)) && (ch >= first) && (ch <= lastc);
   endfunction

   // ------------------------------------------------------------------------
   // Configuration port. Indexes past the register list are ignored.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_first_ff <= mvt_pkg::ZONE_FIRST_RST;
         zone_last_ff  <= mvt_pkg::ZONE_LAST_RST;
         master_ff     <= mvt_pkg::MASTER_RST;
         normalize_ff  <= 1'b1;
         bend_range_ff <= mvt_pkg::BEND_RANGE_RST;
         semi_mode_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            mvt_pkg::CSR_ZONE_FIRST: zone_first_ff <= csr_wdata[mvt_pkg::CHAN_W-1:0];
            mvt_pkg::CSR_ZONE_LAST:  zone_last_ff  <= csr_wdata[mvt_pkg::CHAN_W-1:0];
            mvt_pkg::CSR_MASTER:     master_ff     <= csr_wdata[mvt_pkg::CHAN_W-1:0];
            mvt_pkg::CSR_NORMALIZE:  normalize_ff  <= csr_wdata[0];
            mvt_pkg::CSR_BEND_RANGE: bend_range_ff <= csr_wdata;
            mvt_pkg::CSR_SEMI_MODE:  semi_mode_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Voice store and shared bend unit.
   // ------------------------------------------------------------------------
   assign walking   = (func_ff == mvt_pkg::FUNC_DUMP) || (func_ff == mvt_pkg::FUNC_FLUSH);
   assign chan_m1   = chan_ff - 5'd1;
   assign walk_chan = 5'(cnt_ff) + 5'd1;
   assign addr      = walking ? cnt_ff : chan_m1[IDX_W-1:0];

   assign store_clear = (state_ff == ST_EXEC) && (func_ff == mvt_pkg::FUNC_RESET);

   mvt_voice_store #(
      .CHANNELS   (CHANNELS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .clear      (store_clear),
      .addr       (addr),
      .wr         (wr),
      .rd         (entry),
      .active_vec (active_vec)
   );

   mvt_bend_unit u_bend (
      .clock         (clock),
      .load          (state_ff == ST_EXEC),
      .raw           (bend_raw_sel),
      .range_semis   (bend_range_ff),
      .semitone_mode (semi_mode_ff),
      .bend          (bend_val)
   );

   // Active voices of the zone that a walk has not reached yet. When none is
   // left past the current channel, the word being formed closes the run.
   always_comb begin
      for (int j = 0; j < CHANNELS; j++) begin
         zone_vec[j] = in_zone(5'(j + 1), zone_first_ff, zone_last_ff);
         rest_vec[j] = active_vec[j] & zone_vec[j] & (IDX_W'(j) > cnt_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Event decode: decides the entry update and the result word for the
   // channel being looked at. Only acts in the execute state.
   // ------------------------------------------------------------------------
   always_comb begin
      inz          = in_zone(chan_ff, zone_first_ff, zone_last_ff);
      walk_inz     = in_zone(walk_chan, zone_first_ff, zone_last_ff);
      v_bend       = (amt_ff == '0) ? 14'd1 : amt_ff;
      v7           = mvt_pkg::sat7(amt_ff);
      has_res      = 1'b0;
      master_we    = 1'b0;
      wr           = '0;
      pend_in      = '0;
      bend_raw_sel = entry.bend_raw;

      if (state_ff == ST_EXEC) begin
         unique case (func_ff)
            mvt_pkg::FUNC_NOTE_ON, mvt_pkg::FUNC_NOTE_OFF: begin
               if (inz) begin
                  if ((func_ff == mvt_pkg::FUNC_NOTE_ON) && (amt_ff != '0)) begin
                     wr.we_active     = 1'b1;
                     wr.active        = 1'b1;
                     wr.we_note       = 1'b1;
                     wr.key           = key_ff;
                     wr.velocity      = v7;
                     has_res          = 1'b1;
                     pend_in.kind     = mvt_pkg::KIND_NOTE;
                     pend_in.chan     = chan_ff;
                     pend_in.key      = key_ff;
                     pend_in.level    = mvt_pkg::level_fmt(v7, normalize_ff);
                     pend_in.use_bend = 1'b1;
                  end else if (entry.active) begin
                     // A note-on of velocity zero releases with level zero.
                     wr.we_active  = 1'b1;
                     wr.active     = 1'b0;
                     has_res       = 1'b1;
                     pend_in.kind  = mvt_pkg::KIND_OFF;
                     pend_in.chan  = chan_ff;
                     pend_in.key   = key_ff;
                     pend_in.level = (func_ff == mvt_pkg::FUNC_NOTE_ON) ? '0 :
                                     mvt_pkg::level_fmt(v7, normalize_ff);
                  end
               end
            end
            mvt_pkg::FUNC_BEND: begin
               bend_raw_sel = v_bend;
               if (chan_ff == master_ff) begin
                  if (v_bend != master_raw_ff) begin
                     master_we        = 1'b1;
                     has_res          = 1'b1;
                     pend_in.kind     = mvt_pkg::KIND_GBEND;
                     pend_in.use_bend = 1'b1;
                  end
               end else if (inz && (v_bend != entry.bend_raw)) begin
                  wr.we_bend       = 1'b1;
                  wr.bend_raw      = v_bend;
                  has_res          = 1'b1;
                  pend_in.kind     = mvt_pkg::KIND_BEND;
                  pend_in.chan     = chan_ff;
                  pend_in.use_bend = 1'b1;
               end
            end
            mvt_pkg::FUNC_CC: begin
               if ((chan_ff != master_ff) && inz && (ctl_ff == mvt_pkg::TIMBRE_CC) &&
                   (v7 != entry.timbre)) begin
                  wr.we_timbre   = 1'b1;
                  wr.timbre      = v7;
                  has_res        = 1'b1;
                  pend_in.kind   = mvt_pkg::KIND_TIMBRE;
                  pend_in.chan   = chan_ff;
                  pend_in.timbre = mvt_pkg::level_fmt(v7, normalize_ff);
               end
            end
            mvt_pkg::FUNC_PRESSURE: begin
               if ((chan_ff != master_ff) && inz && (v7 != entry.pressure)) begin
                  wr.we_pressure   = 1'b1;
                  wr.pressure      = v7;
                  has_res          = 1'b1;
                  pend_in.kind     = mvt_pkg::KIND_PRESSURE;
                  pend_in.chan     = chan_ff;
                  pend_in.pressure = mvt_pkg::level_fmt(v7, normalize_ff);
               end
            end
            mvt_pkg::FUNC_DUMP, mvt_pkg::FUNC_FLUSH: begin
               if (walk_inz && entry.active) begin
                  has_res      = 1'b1;
                  pend_in.chan = walk_chan;
                  pend_in.key  = entry.key;
                  pend_in.last = (rest_vec == '0);
                  if (func_ff == mvt_pkg::FUNC_DUMP) begin
                     pend_in.kind     = mvt_pkg::KIND_STATE;
                     pend_in.level    = mvt_pkg::level_fmt(entry.velocity, normalize_ff);
                     pend_in.timbre   = mvt_pkg::level_fmt(entry.timbre, normalize_ff);
                     pend_in.pressure = mvt_pkg::level_fmt(entry.pressure, normalize_ff);
                     pend_in.use_bend = 1'b1;
                  end else begin
                     pend_in.kind = mvt_pkg::KIND_OFF;
                     wr.we_active = 1'b1;
                     wr.active    = 1'b0;
                  end
               end
            end
            mvt_pkg::FUNC_RESET: begin
               // The store clears itself; the master bend is cleared below.
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------------
   assign req_take = req_ch.valid && req_ch.ready;
   assign out_load = (state_ff == ST_CALC) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_take) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (has_res) begin
               state_in = ST_CALC;
            end else if (walking && (cnt_ff != LAST_IDX)) begin
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CALC: begin
            if (out_load) begin
               if (walking && (cnt_ff != LAST_IDX)) begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         master_raw_ff <= mvt_pkg::BEND_CENTRE;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (store_clear) begin
            master_raw_ff <= mvt_pkg::BEND_CENTRE;
         end else if (master_we) begin
            master_raw_ff <= v_bend;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= req_ch.func;
         chan_ff <= req_ch.chan;
         key_ff  <= req_ch.key;
         ctl_ff  <= req_ch.controller;
         amt_ff  <= req_ch.amount;
      end
      if (state_ff == ST_EXEC) begin
         pend_ff <= pend_in;
      end
      if (out_load) begin
         rsp_word_ff <= pend_ff;
         rsp_bend_ff <= pend_ff.use_bend ? bend_val : '0;
      end
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.kind         = rsp_word_ff.kind;
   assign rsp_ch.out_chan     = rsp_word_ff.chan;
   assign rsp_ch.out_key      = rsp_word_ff.key;
   assign rsp_ch.level        = rsp_word_ff.level;
   assign rsp_ch.bend_out     = rsp_bend_ff;
   assign rsp_ch.timbre_out   = rsp_word_ff.timbre;
   assign rsp_ch.pressure_out = rsp_word_ff.pressure;
   assign rsp_ch.last         = rsp_word_ff.last;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // A reset word leaves no voice active.
   `MVT_ASSERT_NEXT(a_reset_clears, clock, reset, (state_ff == ST_EXEC) && (func_ff == mvt_pkg::FUNC_RESET), active_vec == '0)
   // Only dump and flush runs mark a closing word.
   `MVT_ASSERT_IMPLIES(a_last_kind, clock, reset, rsp_ch.valid && rsp_ch.last, (rsp_ch.kind == mvt_pkg::KIND_STATE) || (rsp_ch.kind == mvt_pkg::KIND_OFF))
   // Global bend carries no channel.
   `MVT_ASSERT_IMPLIES(a_gbend_chan, clock, reset, rsp_ch.valid && (rsp_ch.kind == mvt_pkg::KIND_GBEND), rsp_ch.out_chan == '0)

endmodule

@@ src/mvt_bend_unit.sv @@
// ----------------------------------------------------------------------------
// MPE voice channel tracker bend unit
// Two-step bend formatter: a registered magnitude product, then a
// divide by 8191 done as a fold of the upper bits and one compare.
// ----------------------------------------------------------------------------
module mvt_bend_unit (
   input  logic                                clock,
   input  logic                                load,
   input  logic [mvt_pkg::AMT_W-1:0]           raw,
   input  logic [mvt_pkg::VAL7_W-1:0]          range_semis,
   input  logic                                semitone_mode,
   output logic signed [mvt_pkg::BEND_W-1:0]   bend
);

   logic [mvt_pkg::AMT_W-1:0]  diff;
   logic [mvt_pkg::MAG_W-1:0]  mag;
   logic [mvt_pkg::VAL7_W-1:0] mult;
   logic [mvt_pkg::PROD_W-1:0] prod_in;
   logic [mvt_pkg::PROD_W-1:0] prod_ff;
   logic                       neg_in;
   logic                       neg_ff;
   logic [mvt_pkg::BEND_W-1:0] x;
   logic [9:0]                 hi;
   logic [12:0]                lo;
   logic [13:0]                rem;
   logic                       adj;
   logic [mvt_pkg::BEND_W-1:0] q;

   always_comb begin
      neg_in  = raw < mvt_pkg::BEND_CENTRE;
      diff    = neg_in ? (mvt_pkg::BEND_CENTRE - raw) : (raw - mvt_pkg::BEND_CENTRE);
      mag     = diff[mvt_pkg::MAG_W-1:0];
      mult    = semitone_mode ? range_semis : 7'd1;
      prod_in = {7'b0, mag} * {13'b0, mult};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         neg_ff  <= neg_in;
      end
   end

   // With A = |d| * range, A*32768 = 4A*8191 + 4A, so the result is
   // 4A + (4A + 4095) / 8191, and 8192 = 8191 + 1 folds the high bits back.
   always_comb begin
      x    = {1'b0, prod_ff, 2'b00} + 23'd4095;
      hi   = x[22:13];
      lo   = x[12:0];
      rem  = {4'b0, hi} + {1'b0, lo};
      adj  = rem >= 14'd8191;
      q    = {1'b0, prod_ff, 2'b00} + {13'b0, hi} + {22'b0, adj};
      bend = $signed(neg_ff ? (23'd0 - q) : q);
   end

endmodule

@@ src/mvt_voice_store.sv @@
// ----------------------------------------------------------------------------
// MPE voice channel tracker voice store
// Per-channel voice entries with one shared address for read and write.
// ----------------------------------------------------------------------------
module mvt_voice_store #(
   parameter int CHANNELS = mvt_pkg::CHANNELS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  logic [$clog2(CHANNELS)-1:0]    addr,
   input  mvt_pkg::voice_wr_type          wr,
   output mvt_pkg::voice_entry_type       rd,
   output logic [CHANNELS-1:0]            active_vec
);

   localparam int IDX_W = $clog2(CHANNELS);

   logic [CHANNELS-1:0]              active_ff;
   logic [mvt_pkg::KEY_W-1:0]        key_ff      [CHANNELS];
   logic [mvt_pkg::VAL7_W-1:0]       velocity_ff [CHANNELS];
   logic [mvt_pkg::AMT_W-1:0]        bend_ff     [CHANNELS];
   logic [mvt_pkg::VAL7_W-1:0]       timbre_ff   [CHANNELS];
   logic [mvt_pkg::VAL7_W-1:0]       pressure_ff [CHANNELS];

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         active_ff <= '0;
         for (int j = 0; j < CHANNELS; j++) begin
            key_ff[j]      <= '0;
            velocity_ff[j] <= '0;
            bend_ff[j]     <= mvt_pkg::BEND_CENTRE;
            timbre_ff[j]   <= '0;
            pressure_ff[j] <= '0;
         end
      end else begin
         if (wr.we_active) begin
            active_ff[addr] <= wr.active;
         end
         if (wr.we_note) begin
            key_ff[addr]      <= wr.key;
            velocity_ff[addr] <= wr.velocity;
         end
         if (wr.we_bend) begin
            bend_ff[addr] <= wr.bend_raw;
         end
         if (wr.we_timbre) begin
            timbre_ff[addr] <= wr.timbre;
         end
         if (wr.we_pressure) begin
            pressure_ff[addr] <= wr.pressure;
         end
      end
   end

   always_comb begin
      rd.active   = active_ff[addr];
      rd.key      = key_ff[addr];
      rd.velocity = velocity_ff[addr];
      rd.bend_raw = bend_ff[addr];
      rd.timbre   = timbre_ff[addr];
      rd.pressure = pressure_ff[addr];
   end

   assign active_vec = active_ff;

   // IDX_W documents the address width taken by this store.
   logic [IDX_W-1:0] addr_chk;
   assign addr_chk = addr;

endmodule

@@ bench/tb_mpe_voice_channel_tracker.sv @@
// ----------------------------------------------------------------------------
// MPE voice channel tracker testbench
// Drives MIDI event words into the tracker under random sender bursts and
// receiver stalls, predicts every result word from a model of the per-channel
// voice state, and checks each result word field by field in order.
// ----------------------------------------------------------------------------
module tb_mpe_voice_channel_tracker;
   import mvt_pkg::*;

   localparam int CHANNELS = CHANNELS_DEF;

   // A dump or flush walks every channel, so the block may stay busy after the
   // last expected word has been taken, while it passes channels with nothing to
   // report. The settle wait covers that walk.
   localparam int SETTLE_CYCLES = 2 * CHANNELS + 16;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PRINT_LIMIT   = 40;

   // Bend values at the two ends of the normalized scale.
   localparam logic [BEND_W-1:0] BEND_FULL_DOWN = 23'h7f8000;
   localparam logic [BEND_W-1:0] BEND_FULL_UP   = 23'd32768;

   // Receiver stall patterns.
   localparam int READY_ALWAYS   = 0;
   localparam int READY_COIN     = 1;
   localparam int READY_PERIODIC = 2;
   localparam int READY_SPARSE   = 3;

   // One result word as the block should present it.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CHAN_W-1:0]  chan;
      logic [KEY_W-1:0]   key;
      logic [LEVEL_W-1:0] level;
      logic [BEND_W-1:0]  bend;
      logic [LEVEL_W-1:0] timbre;
      logic [LEVEL_W-1:0] pressure;
      logic               last;
   } tracker_word_t;

   // One row of the directed script. When has_word is set, the row's result is
   // written out by hand in word instead of being taken from the predictor.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CHAN_W-1:0] chan;
      logic [KEY_W-1:0]  key;
      logic [CTL_W-1:0]  ctl;
      logic [AMT_W-1:0]  amt;
      logic              has_word;
      tracker_word_t     word;
   } script_row_t;

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mvt_req_if req_if ();
   mvt_rsp_if rsp_if ();

   mpe_voice_channel_tracker DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the block's registers and voice entries.
   logic [CHAN_W-1:0] cfg_first;
   logic [CHAN_W-1:0] cfg_last;
   logic [CHAN_W-1:0] cfg_master;
   logic              cfg_norm;
   logic [VAL7_W-1:0] cfg_semis;
   logic              cfg_semi;
   voice_entry_type   voices [CHANNELS];
   logic [AMT_W-1:0]  master_bend;

   tracker_word_t pending_words [$];
   tracker_word_t want_word;
   script_row_t   script_rows [$];

   int error_count = 0;
   int words_seen  = 0;
   int cycle_count = 0;
   int burst_left  = 0;
   int stall_mode  = READY_ALWAYS;
   int stall_left  = 0;
   int stall_phase = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Failure reporting. Every mismatch is counted; only the first few print.
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("mismatch at cycle %0d, word %0d: %s", cycle_count, words_seen, msg);
      end
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   // ------------------------------------------------------------------------
   // Predictor. Levels are kept raw in the voice entries and formatted on the
   // way out, exactly as the block does.
   // ------------------------------------------------------------------------
   function automatic logic [VAL7_W-1:0] to_val7(input logic [AMT_W-1:0] amt);
      return (amt > 127) ? 7'd127 : amt[VAL7_W-1:0];
   endfunction

   function automatic logic [LEVEL_W-1:0] fmt_level(input logic [VAL7_W-1:0] v);
      int unsigned q;
      q = v;
      if (!cfg_norm) begin
         return q[LEVEL_W-1:0];
      end
      // Q0.15 with round-to-nearest; full scale 127 saturates just below one.
      q = (q * 32768 + 63) / 127;
      return (q > 32767) ? 15'h7fff : q[LEVEL_W-1:0];
   endfunction

   function automatic logic [BEND_W-1:0] fmt_bend(input logic [AMT_W-1:0] raw);
      int              d;
      longint unsigned mag;
      longint unsigned q;
      d = int'(raw) - int'(BEND_CENTRE);
      // Raw 0 and raw 1 both mean full negative bend.
      if (d < -8191) begin
         d = -8191;
      end
      mag = (d < 0) ? -d : d;
      if (cfg_semi) begin
         q = (mag * cfg_semis * 32768 + 4095) / 8191;
      end else begin
         q = (mag * 32768 + 4095) / 8191;
      end
      if (d < 0) begin
         q = -q;
      end
      return q[BEND_W-1:0];
   endfunction

   function automatic bit in_zone(input logic [CHAN_W-1:0] ch);
      return ch >= 1 && ch <= CHANNELS && ch >= cfg_first && ch <= cfg_last;
   endfunction

   function automatic tracker_word_t make_word(
      input logic [KIND_W-1:0] kind, input logic [CHAN_W-1:0] ch,
      input logic [KEY_W-1:0] key, input logic [LEVEL_W-1:0] level,
      input logic [BEND_W-1:0] bend, input logic [LEVEL_W-1:0] timbre,
      input logic [LEVEL_W-1:0] pressure, input logic last);
      tracker_word_t w;
      w.kind     = kind;
      w.chan     = ch;
      w.key      = key;
      w.level    = level;
      w.bend     = bend;
      w.timbre   = timbre;
      w.pressure = pressure;
      w.last     = last;
      return w;
   endfunction

   function automatic void clear_voices();
      for (int c = 0; c < CHANNELS; c++) begin
         voices[c] = '0;
         voices[c].bend_raw = BEND_CENTRE;
      end
      master_bend = BEND_CENTRE;
   endfunction

   // Applies one accepted event word to the shadow state and queues the result
   // words it causes. Returns 1 when the event changed state or gave a result,
   // 0 when the block simply ignores it.
   function automatic bit track_event(
      input logic [FUNC_W-1:0] func, input logic [CHAN_W-1:0] ch,
      input logic [KEY_W-1:0] key, input logic [CTL_W-1:0] ctl,
      input logic [AMT_W-1:0] amt);
      int                i;
      int                n;
      logic [AMT_W-1:0]  bend_v;
      logic [VAL7_W-1:0] v;
      tracker_word_t     held;
      i = int'(ch) - 1;
      n = 0;
      case (func)
         FUNC_NOTE_ON, FUNC_NOTE_OFF: begin
            if (!in_zone(ch)) begin
               return 0;
            end
            if (func == FUNC_NOTE_ON && amt != 0) begin
               voices[i].active   = 1'b1;
               voices[i].key      = key;
               voices[i].velocity = to_val7(amt);
               pending_words.push_back(make_word(KIND_NOTE, ch, key,
                  fmt_level(voices[i].velocity), fmt_bend(voices[i].bend_raw), 0, 0, 0));
               return 1;
            end
            // A note-on with velocity 0 is a note-off with release velocity 0.
            if (!voices[i].active) begin
               return 0;
            end
            voices[i].active = 1'b0;
            pending_words.push_back(make_word(KIND_OFF, ch, key,
               (func == FUNC_NOTE_ON) ? '0 : fmt_level(to_val7(amt)), 0, 0, 0, 0));
            return 1;
         end
         FUNC_BEND: begin
            bend_v = (amt == 0) ? 14'd1 : amt;
            if (ch == cfg_master) begin
               if (bend_v == master_bend) begin
                  return 0;
               end
               master_bend = bend_v;
               pending_words.push_back(make_word(KIND_GBEND, 0, 0, 0, fmt_bend(bend_v),
                                                 0, 0, 0));
               return 1;
            end
            if (!in_zone(ch) || bend_v == voices[i].bend_raw) begin
               return 0;
            end
            voices[i].bend_raw = bend_v;
            pending_words.push_back(make_word(KIND_BEND, ch, 0, 0, fmt_bend(bend_v),
                                              0, 0, 0));
            return 1;
         end
         FUNC_CC: begin
            if (ch == cfg_master || !in_zone(ch) || ctl != TIMBRE_CC) begin
               return 0;
            end
            v = to_val7(amt);
            if (v == voices[i].timbre) begin
               return 0;
            end
            voices[i].timbre = v;
            pending_words.push_back(make_word(KIND_TIMBRE, ch, 0, 0, 0, fmt_level(v), 0, 0));
            return 1;
         end
         FUNC_PRESSURE: begin
            if (ch == cfg_master || !in_zone(ch)) begin
               return 0;
            end
            v = to_val7(amt);
            if (v == voices[i].pressure) begin
               return 0;
            end
            voices[i].pressure = v;
            pending_words.push_back(make_word(KIND_PRESSURE, ch, 0, 0, 0, 0,
                                              fmt_level(v), 0));
            return 1;
         end
         FUNC_DUMP, FUNC_FLUSH: begin
            // Each word is held back one step so the final one can be marked.
            for (int c = 1; c <= CHANNELS; c++) begin
               if (in_zone(c) && voices[c-1].active) begin
                  if (n > 0) begin
                     pending_words.push_back(held);
                  end
                  if (func == FUNC_DUMP) begin
                     held = make_word(KIND_STATE, c, voices[c-1].key,
                                      fmt_level(voices[c-1].velocity),
                                      fmt_bend(voices[c-1].bend_raw),
                                      fmt_level(voices[c-1].timbre),
                                      fmt_level(voices[c-1].pressure), 0);
                  end else begin
                     held = make_word(KIND_OFF, c, voices[c-1].key, 0, 0, 0, 0, 0);
                     voices[c-1].active = 1'b0;
                  end
                  n++;
               end
            end
            if (n == 0) begin
               return 0;
            end
            held.last = 1'b1;
            pending_words.push_back(held);
            return 1;
         end
         default: begin
            clear_voices();
            return 1;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Sender. Words go out in bursts of random length; between bursts valid
   // may drop for a random number of cycles. Within a burst valid stays high.
   // ------------------------------------------------------------------------
   task automatic send_word(input logic [FUNC_W-1:0] func, input logic [CHAN_W-1:0] ch,
                            input logic [KEY_W-1:0] key, input logic [CTL_W-1:0] ctl,
                            input logic [AMT_W-1:0] amt);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 12);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid      <= 1'b1;
      req_if.func       <= func;
      req_if.chan       <= ch;
      req_if.key        <= key;
      req_if.controller <= ctl;
      req_if.amount     <= amt;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Stops sending, waits for every expected word, then lets the block finish
   // any walk that produced no further words.
   task automatic drain_and_wait();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Configuration. All six registers are written back to back; the shadow
   // copy follows at once, since the block is idle here.
   // ------------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [CHAN_W-1:0] first, input logic [CHAN_W-1:0] last,
                               input logic [CHAN_W-1:0] master, input logic norm,
                               input logic [VAL7_W-1:0] semis, input logic semi);
      write_reg(CSR_ZONE_FIRST, CSR_DATA_W'(first));
      write_reg(CSR_ZONE_LAST,  CSR_DATA_W'(last));
      write_reg(CSR_MASTER,     CSR_DATA_W'(master));
      write_reg(CSR_NORMALIZE,  CSR_DATA_W'(norm));
      write_reg(CSR_BEND_RANGE, CSR_DATA_W'(semis));
      write_reg(CSR_SEMI_MODE,  CSR_DATA_W'(semi));
      csr_we     <= 1'b0;
      cfg_first  = first;
      cfg_last   = last;
      cfg_master = master;
      cfg_norm   = norm;
      cfg_semis  = semis;
      cfg_semi   = semi;
   endtask

   // ------------------------------------------------------------------------
   // Random stimulus. Most events land on zone channels, and note-offs mostly
   // and expression often target voices that are sounding, so that the voice
   // entries are exercised rather than skipped.
   // ------------------------------------------------------------------------
   function automatic logic [CHAN_W-1:0] pick_channel(input bit want_active);
      int lo;
      int hi;
      int r;
      int cands [$];
      lo = (cfg_first < 1) ? 1 : cfg_first;
      hi = (cfg_last > CHANNELS) ? CHANNELS : cfg_last;
      if (want_active) begin
         for (int c = lo; c <= hi; c++) begin
            if (voices[c-1].active) begin
               cands.push_back(c);
            end
         end
      end
      if (cands.size() != 0) begin
         return cands[$urandom_range(0, cands.size() - 1)];
      end
      r = $urandom_range(0, 99);
      if (r < 70 && lo <= hi) begin
         return $urandom_range(lo, hi);
      end
      if (r < 85) begin
         return cfg_master;
      end
      return $urandom_range(1, CHANNELS);
   endfunction

   // A 7-bit style amount: often a repeat-prone small set, sometimes a value
   // that needs saturation.
   function automatic logic [AMT_W-1:0] pick_level_amount();
      case ($urandom_range(0, 9))
         0:       return 14'd0;
         1:       return 14'd127;
         2:       return 14'd64;
         3:       return $urandom_range(0, 16383);
         default: return $urandom_range(0, 127);
      endcase
   endfunction

   task automatic random_event(output bit acted);
      logic [FUNC_W-1:0] func;
      logic [CHAN_W-1:0] ch;
      logic [KEY_W-1:0]  key;
      logic [CTL_W-1:0]  ctl;
      logic [AMT_W-1:0]  amt;
      int                r;
      r   = $urandom_range(0, 99);
      key = $urandom_range(0, 127);
      ctl = $urandom_range(0, 127);
      amt = pick_level_amount();
      if (r < 26) begin
         func = FUNC_NOTE_ON;
         ch   = pick_channel(0);
         if ($urandom_range(0, 9) == 0) begin
            amt = 0;
         end else if (amt == 0) begin
            amt = $urandom_range(1, 127);
         end
      end else if (r < 38) begin
         func = FUNC_NOTE_OFF;
         ch   = pick_channel($urandom_range(0, 9) < 7);
      end else if (r < 56) begin
         func = FUNC_BEND;
         ch   = pick_channel($urandom_range(0, 1));
         case ($urandom_range(0, 19))
            0:       amt = 14'd0;
            1:       amt = 14'd1;
            2:       amt = BEND_CENTRE;
            3:       amt = 14'd16383;
            default: amt = $urandom_range(0, 16383);
         endcase
      end else if (r < 71) begin
         func = FUNC_CC;
         ch   = pick_channel($urandom_range(0, 1));
         if ($urandom_range(0, 4) != 0) begin
            ctl = TIMBRE_CC;
         end
      end else if (r < 86) begin
         func = FUNC_PRESSURE;
         ch   = pick_channel($urandom_range(0, 1));
      end else if (r < 93) begin
         func = FUNC_DUMP;
         ch   = $urandom_range(1, CHANNELS);
      end else if (r < 98) begin
         func = FUNC_FLUSH;
         ch   = $urandom_range(1, CHANNELS);
      end else begin
         func = FUNC_RESET;
         ch   = $urandom_range(1, CHANNELS);
      end
      send_word(func, ch, key, ctl, amt);
      acted = track_event(func, ch, key, ctl, amt);
   endtask

   // One configuration phase: settle, program, then random events until the
   // given number of events has had an effect. Halfway through, the sender
   // may hold off until every expected word has come back.
   task automatic run_phase(input logic [CHAN_W-1:0] first, input logic [CHAN_W-1:0] last,
                            input logic [CHAN_W-1:0] master, input logic norm,
                            input logic [VAL7_W-1:0] semis, input logic semi,
                            input int target, input bit hold_midway);
      int acted_count;
      bit acted;
      bit held;
      drain_and_wait();
      program_regs(first, last, master, norm, semis, semi);
      acted_count = 0;
      held = 0;
      while (acted_count < target) begin
         if (hold_midway && !held && acted_count >= target / 2) begin
            held = 1;
            req_if.valid <= 1'b0;
            burst_left = 0;
            while (pending_words.size() != 0) @(posedge clock);
         end
         random_event(acted);
         if (acted) begin
            acted_count++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver. Ready follows one of several patterns, each held for a random
   // stretch: always ready, a coin flip, a fixed on/off cycle, and mostly
   // stalled.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(READY_ALWAYS, READY_SPARSE);
         stall_left <= $urandom_range(40, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_phase <= (stall_phase == 6) ? 0 : stall_phase + 1;
      case (stall_mode)
         READY_ALWAYS:   rsp_if.ready <= 1'b1;
         READY_COIN:     rsp_if.ready <= ($urandom_range(0, 1) == 1);
         READY_PERIODIC: rsp_if.ready <= (stall_phase < 3);
         default:        rsp_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // ------------------------------------------------------------------------
   // Result checking. Every word taken from the block is matched against the
   // oldest expected word, field by field.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("result word of kind %0d, channel %0d with none expected",
                                      rsp_if.kind, rsp_if.out_chan));
         end else begin
            want_word = pending_words.pop_front();
            check_field("kind",         rsp_if.kind,               want_word.kind);
            check_field("out_chan",     rsp_if.out_chan,           want_word.chan);
            check_field("out_key",      rsp_if.out_key,            want_word.key);
            check_field("level",        rsp_if.level,              want_word.level);
            check_field("bend_out",     $unsigned(rsp_if.bend_out), want_word.bend);
            check_field("timbre_out",   rsp_if.timbre_out,         want_word.timbre);
            check_field("pressure_out", rsp_if.pressure_out,       want_word.pressure);
            check_field("last",         rsp_if.last,               want_word.last);
         end
         words_seen++;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_mpe_voice_channel_tracker: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Directed script, run under the reset configuration: zone 2..16, master
   // channel 1, normalized levels, normalized bend.
   // ------------------------------------------------------------------------
   function automatic script_row_t plain_row(
      input logic [FUNC_W-1:0] func, input logic [CHAN_W-1:0] ch,
      input logic [KEY_W-1:0] key, input logic [CTL_W-1:0] ctl,
      input logic [AMT_W-1:0] amt);
      script_row_t row;
      row.func     = func;
      row.chan     = ch;
      row.key      = key;
      row.ctl      = ctl;
      row.amt      = amt;
      row.has_word = 1'b0;
      row.word     = '0;
      return row;
   endfunction

   function automatic script_row_t typed_row(
      input logic [FUNC_W-1:0] func, input logic [CHAN_W-1:0] ch,
      input logic [KEY_W-1:0] key, input logic [CTL_W-1:0] ctl,
      input logic [AMT_W-1:0] amt, input tracker_word_t word);
      script_row_t row;
      row = plain_row(func, ch, key, ctl, amt);
      row.has_word = 1'b1;
      row.word     = word;
      return row;
   endfunction

   task automatic build_script();
      // Velocity extremes at both ends of the zone, one of them saturated.
      script_rows.push_back(typed_row(FUNC_NOTE_ON, 2, 0, 0, 127,
         make_word(KIND_NOTE, 2, 0, 15'h7fff, 0, 0, 0, 0)));
      script_rows.push_back(typed_row(FUNC_NOTE_ON, 16, 127, 127, 16383,
         make_word(KIND_NOTE, 16, 127, 15'h7fff, 0, 0, 0, 0)));
      // The master channel lies outside the zone, so its note-on is dropped.
      script_rows.push_back(plain_row(FUNC_NOTE_ON, 1, 64, 0, 64));
      // Master bend: raw 0 saturates to raw 1, and a move between them is no
      // change at all.
      script_rows.push_back(typed_row(FUNC_BEND, 1, 0, 0, 0,
         make_word(KIND_GBEND, 0, 0, 0, BEND_FULL_DOWN, 0, 0, 0)));
      script_rows.push_back(plain_row(FUNC_BEND, 1, 0, 0, 1));
      script_rows.push_back(typed_row(FUNC_BEND, 1, 0, 0, 16383,
         make_word(KIND_GBEND, 0, 0, 0, BEND_FULL_UP, 0, 0, 0)));
      // Per-channel bend: centre is no change, raw 0 is full down.
      script_rows.push_back(plain_row(FUNC_BEND, 2, 0, 0, BEND_CENTRE));
      script_rows.push_back(typed_row(FUNC_BEND, 2, 0, 0, 0,
         make_word(KIND_BEND, 2, 0, 0, BEND_FULL_DOWN, 0, 0, 0)));
      // Timbre saturates; other controllers and the master channel are ignored.
      script_rows.push_back(typed_row(FUNC_CC, 2, 0, TIMBRE_CC, 16383,
         make_word(KIND_TIMBRE, 2, 0, 0, 0, 15'h7fff, 0, 0)));
      script_rows.push_back(plain_row(FUNC_CC, 2, 0, 73, 5));
      script_rows.push_back(plain_row(FUNC_CC, 1, 0, TIMBRE_CC, 5));
      // Pressure on a silent voice is stored; a repeat is no change.
      script_rows.push_back(typed_row(FUNC_PRESSURE, 3, 0, 0, 1,
         make_word(KIND_PRESSURE, 3, 0, 0, 0, 0, 15'd258, 0)));
      script_rows.push_back(plain_row(FUNC_PRESSURE, 3, 0, 0, 1));
      script_rows.push_back(plain_row(FUNC_PRESSURE, 1, 0, 0, 9));
      // Note-off, or note-on at velocity 0, on an inactive voice gives nothing.
      script_rows.push_back(plain_row(FUNC_NOTE_OFF, 5, 9, 0, 10));
      script_rows.push_back(plain_row(FUNC_NOTE_ON, 3, 60, 0, 0));
      script_rows.push_back(plain_row(FUNC_NOTE_ON, 3, 60, 0, 100));
      // Velocity 0 ends the voice; the off word carries the input key.
      script_rows.push_back(typed_row(FUNC_NOTE_ON, 3, 61, 0, 0,
         make_word(KIND_OFF, 3, 61, 0, 0, 0, 0, 0)));
      script_rows.push_back(plain_row(FUNC_NOTE_ON, 4, 33, 0, 1));
      script_rows.push_back(plain_row(FUNC_DUMP, 1, 0, 0, 0));
      script_rows.push_back(typed_row(FUNC_NOTE_OFF, 2, 5, 0, 0,
         make_word(KIND_OFF, 2, 5, 0, 0, 0, 0, 0)));
      script_rows.push_back(plain_row(FUNC_FLUSH, 1, 0, 0, 0));
      // Channels outside the legal range are never in the zone.
      script_rows.push_back(plain_row(FUNC_NOTE_ON, 0, 1, 0, 1));
      script_rows.push_back(plain_row(FUNC_BEND, 31, 0, 0, 100));
      // Clear with a voice sounding, then an empty dump.
      script_rows.push_back(plain_row(FUNC_NOTE_ON, 6, 7, 0, 50));
      script_rows.push_back(plain_row(FUNC_RESET, 1, 0, 0, 0));
      script_rows.push_back(plain_row(FUNC_DUMP, 1, 0, 0, 0));
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      int          n_before;
      bit          acted;
      script_row_t row;

      clock             = 1'b0;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.func       = FUNC_NOTE_ON;
      req_if.chan       = '0;
      req_if.key        = '0;
      req_if.controller = '0;
      req_if.amount     = '0;
      rsp_if.ready      = 1'b0;

      // The shadow state starts from the block's reset values.
      cfg_first  = ZONE_FIRST_RST;
      cfg_last   = ZONE_LAST_RST;
      cfg_master = MASTER_RST;
      cfg_norm   = 1'b1;
      cfg_semis  = BEND_RANGE_RST;
      cfg_semi   = 1'b0;
      clear_voices();

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows. The predictor always runs so the shadow state stays in
      // step; where a row carries a hand-written word, that word replaces
      // whatever the predictor queued for it.
      build_script();
      foreach (script_rows[r]) begin
         row = script_rows[r];
         send_word(row.func, row.chan, row.key, row.ctl, row.amt);
         n_before = pending_words.size();
         acted = track_event(row.func, row.chan, row.key, row.ctl, row.amt);
         if (row.has_word) begin
            while (pending_words.size() > n_before) begin
               void'(pending_words.pop_back());
            end
            pending_words.push_back(row.word);
         end
      end

      // Random phases, each under its own register setting. The second one
      // has first after last, so only master bend gets through.
      run_phase(1,  16, 16, 1'b0, 96, 1'b1, 55, 1'b1);
      run_phase(9,  4,  3,  1'b1, 0,  1'b1, 20, 1'b0);
      run_phase(16, 16, 16, 1'b1, 0,  1'b1, 45, 1'b0);
      run_phase(1,  15, 8,  1'b0, 1,  1'b1, 55, 1'b1);
      run_phase(1,  1,  16, 1'b1, 48, 1'b0, 40, 1'b0);
      run_phase(2,  16, 1,  1'b1, 48, 1'b0, 55, 1'b1);

      drain_and_wait();
      if (pending_words.size() != 0) begin
         report_mismatch($sformatf("%0d expected words never arrived", pending_words.size()));
      end
      if (error_count == 0) begin
         $display("tb_mpe_voice_channel_tracker: done, clean");
      end else begin
         $display("tb_mpe_voice_channel_tracker: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/mvt_pkg.sv
src/mvt_if.sv
src/mvt_bend_unit.sv
src/mvt_voice_store.sv
src/mpe_voice_channel_tracker.sv
bench/tb_mpe_voice_channel_tracker.sv
